// ----- rtl/ra_pkg.sv -----
// ----------------------------------------------------------------------------
// ra_pkg
// shared types, widths and codes for the rational accumulator unit
// ----------------------------------------------------------------------------
package ra_pkg;

	localparam int VALUE_WIDTH = 32;
	// the fields are 32 bits wide, so the value range never exceeds that
	localparam int EFF_W = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
	localparam int OPD_W = 32;
	localparam int MAG_W = 2 * OPD_W;
	localparam int DEN_OUT_W = OPD_W - 1;
	localparam int CNT_W = $clog2(MAG_W + 1);
	localparam int K_W = $clog2(MAG_W);

	localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (EFF_W - 1);

	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_ADD  = 2'd1,
		KIND_INC  = 2'd2,
		KIND_DEC  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PREP,
		OP_MUL_A,
		OP_MUL_B,
		OP_MUL_D,
		OP_SUM,
		OP_GCD_INIT,
		OP_GCD_STEP,
		OP_DIVN_INIT,
		OP_DIVD_INIT,
		OP_DIV_STEP,
		OP_WB_N,
		OP_WB_D,
		OP_COMMIT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_D,
		ST_SUM,
		ST_GCD_INIT,
		ST_GCD,
		ST_DIV_N,
		ST_DIVD_INIT,
		ST_DIV_D,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  den_zero;
		logic  num_zero;
		logic  gcd_done;
		logic  div_done;
	} status_t;

endpackage

// ----- rtl/rational_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// rational_accumulator_unit
// signed rational accumulator kept in lowest terms with a positive denominator
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry kind and an operand fraction;
//   a transaction is taken when in_valid is high and in_stall is low
// output channel: out_valid / out_stall carry the reduced value and an
//   error code, one result transaction per input transaction
// kinds: load a fraction, add a fraction, increment or decrement by one
// errors: zero denominator or a reduced value beyond the range keep the
//   old value, which the result then shows
// timing: one transaction is worked on at a time; in_stall is high from
//   the cycle after acceptance until the result is registered
// sequence: a zero-denominator error goes from the prep step straight to
//   commit; other items run binary gcd steps (one subtract or shift a
//   cycle) and then both divisions by the gcd on one restoring divider, a
//   zero value skipping both; an add first forms three products on the
//   shared 32 x 32 multiplier and the sum
// stall: the result waits in the output register; a new transaction may
//   be taken meanwhile, and its own commit waits until that slot frees
// reset: arst_n clears the value to 0/1 and drops out_valid
// ----------------------------------------------------------------------------
module rational_accumulator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         kind,
	input  logic signed [ra_pkg::OPD_W-1:0]    operand_numerator,
	input  logic signed [ra_pkg::OPD_W-1:0]    operand_denominator,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ra_pkg::OPD_W-1:0]    result_numerator,
	output logic [ra_pkg::DEN_OUT_W-1:0]       result_denominator,
	output logic [1:0]                         error
);

	// command and status between sequencer and datapath
	ra_pkg::cmd_t    cmd;
	ra_pkg::status_t status;

	ra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// operands are sampled on the accept cycle only
	ra_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.kind                (kind),
		.operand_numerator   (operand_numerator),
		.operand_denominator (operand_denominator),
		.result_numerator    (result_numerator),
		.result_denominator  (result_denominator),
		.error               (error)
	);

endmodule

// ----- rtl/ra_ctrl.sv -----
// ----------------------------------------------------------------------------
// ra_ctrl
// sequencer for load, add, increment, decrement, gcd reduction and commit of one transaction
// ----------------------------------------------------------------------------
module ra_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  ra_pkg::status_t  status,
	output ra_pkg::cmd_t     cmd
);

	ra_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;
	logic commit_fire;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ra_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ra_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit_fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = ra_pkg::OP_NONE;
		commit_fire = 1'b0;
		unique case (state_q)
			ra_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op = ra_pkg::OP_LOAD;
					state_d = ra_pkg::ST_PREP;
				end
			end
			ra_pkg::ST_PREP: begin
				cmd.op = ra_pkg::OP_PREP;
				if ((status.kind == ra_pkg::KIND_LOAD || status.kind == ra_pkg::KIND_ADD)
						&& status.den_zero)
					state_d = ra_pkg::ST_COMMIT;
				else if (status.kind == ra_pkg::KIND_ADD)
					state_d = ra_pkg::ST_MUL_A;
				else
					state_d = ra_pkg::ST_GCD_INIT;
			end
			ra_pkg::ST_MUL_A: begin
				cmd.op = ra_pkg::OP_MUL_A;
				state_d = ra_pkg::ST_MUL_B;
			end
			ra_pkg::ST_MUL_B: begin
				cmd.op = ra_pkg::OP_MUL_B;
				state_d = ra_pkg::ST_MUL_D;
			end
			ra_pkg::ST_MUL_D: begin
				cmd.op = ra_pkg::OP_MUL_D;
				state_d = ra_pkg::ST_SUM;
			end
			ra_pkg::ST_SUM: begin
				cmd.op = ra_pkg::OP_SUM;
				state_d = ra_pkg::ST_GCD_INIT;
			end
			ra_pkg::ST_GCD_INIT: begin
				cmd.op = ra_pkg::OP_GCD_INIT;
				state_d = status.num_zero ? ra_pkg::ST_COMMIT : ra_pkg::ST_GCD;
			end
			ra_pkg::ST_GCD: begin
				if (status.gcd_done) begin
					cmd.op = ra_pkg::OP_DIVN_INIT;
					state_d = ra_pkg::ST_DIV_N;
				end else begin
					cmd.op = ra_pkg::OP_GCD_STEP;
				end
			end
			ra_pkg::ST_DIV_N: begin
				if (status.div_done) begin
					cmd.op = ra_pkg::OP_WB_N;
					state_d = ra_pkg::ST_DIVD_INIT;
				end else begin
					cmd.op = ra_pkg::OP_DIV_STEP;
				end
			end
			ra_pkg::ST_DIVD_INIT: begin
				cmd.op = ra_pkg::OP_DIVD_INIT;
				state_d = ra_pkg::ST_DIV_D;
			end
			ra_pkg::ST_DIV_D: begin
				if (status.div_done) begin
					cmd.op = ra_pkg::OP_WB_D;
					state_d = ra_pkg::ST_COMMIT;
				end else begin
					cmd.op = ra_pkg::OP_DIV_STEP;
				end
			end
			ra_pkg::ST_COMMIT: begin
				if (out_free) begin
					cmd.op = ra_pkg::OP_COMMIT;
					commit_fire = 1'b1;
					state_d = ra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ra_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/ra_datapath.sv -----
// ----------------------------------------------------------------------------
// ra_datapath
// accumulator state, shared multiplier, binary gcd and restoring divider
// ----------------------------------------------------------------------------
module ra_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ra_pkg::cmd_t                       cmd,
	output ra_pkg::status_t                    status,
	input  logic [1:0]                         kind,
	input  logic signed [ra_pkg::OPD_W-1:0]    operand_numerator,
	input  logic signed [ra_pkg::OPD_W-1:0]    operand_denominator,
	output logic signed [ra_pkg::OPD_W-1:0]    result_numerator,
	output logic [ra_pkg::DEN_OUT_W-1:0]       result_denominator,
	output logic [1:0]                         error
);

	localparam int OW = ra_pkg::OPD_W;
	localparam int MW = ra_pkg::MAG_W;

	logic signed [OW-1:0] acc_num_q;
	logic [OW-1:0]        acc_den_q;

	ra_pkg::kind_t kind_q;
	logic          on_q;
	logic [OW-1:0] om_q, dmag_q, am_q, ad_q;
	logic          an_q;
	logic [MW-1:0] prod_a_q, prod_b_q;
	logic          pn_q;
	logic [MW-1:0] pm_q, pd_q;
	logic          err1_q;
	logic [MW-1:0] ga_q, gb_q;
	logic [ra_pkg::K_W-1:0] gk_q;
	logic [MW-1:0] div_rem_q, div_quo_q, div_dvs_q;
	logic [ra_pkg::CNT_W-1:0] div_cnt_q;
	logic signed [OW-1:0] res_num_q;
	logic [OW-1:0]        res_den_q;
	logic [1:0]           res_err_q;

	// operand split into sign and magnitude
	logic          in_on, in_dn;
	logic [OW-1:0] in_om, in_dmag;
	logic          eff_on;
	logic [OW-1:0] mul_x, mul_y;
	logic [MW-1:0] mul_p;
	logic [MW-1:0] rem_sh, rem_sub;
	logic          rem_ge;
	logic          sum_n;
	logic [MW-1:0] sum_m;
	logic [MW-1:0] sa_m, sb_m;
	logic          sa_n, sb_n;
	logic          range_bad;
	logic [MW-1:0] neg_lim;

	assign in_on = operand_numerator[OW-1];
	assign in_dn = operand_denominator[OW-1];
	assign in_om = in_on ? (~operand_numerator + OW'(1)) : operand_numerator;
	assign in_dmag = in_dn ? (~operand_denominator + OW'(1)) : operand_denominator;
	// sign already folds in the denominator sign; a zero numerator is positive
	assign eff_on = on_q && (om_q != '0);

	always_comb begin
		case (cmd.op)
			ra_pkg::OP_MUL_A: begin mul_x = am_q; mul_y = dmag_q; end
			ra_pkg::OP_MUL_B: begin mul_x = om_q; mul_y = ad_q; end
			default:          begin mul_x = ad_q; mul_y = dmag_q; end
		endcase
		mul_p = MW'(mul_x) * MW'(mul_y);
	end

	// signed-magnitude add for sum, increment and decrement paths
	always_comb begin
		if (cmd.op == ra_pkg::OP_SUM) begin
			sa_n = an_q;  sa_m = prod_a_q;
			sb_n = eff_on; sb_m = prod_b_q;
		end else begin
			sa_n = an_q;  sa_m = MW'(am_q);
			sb_n = (kind_q == ra_pkg::KIND_DEC); sb_m = MW'(ad_q);
		end
		if (sa_n == sb_n) begin
			sum_n = sa_n; sum_m = sa_m + sb_m;
		end else if (sa_m >= sb_m) begin
			sum_n = sa_n; sum_m = sa_m - sb_m;
		end else begin
			sum_n = sb_n; sum_m = sb_m - sa_m;
		end
	end

	assign rem_sh = {div_rem_q[MW-2:0], div_quo_q[MW-1]};
	assign rem_ge = (rem_sh >= div_dvs_q);
	assign rem_sub = rem_sh - div_dvs_q;

	assign neg_lim = pn_q ? ra_pkg::HALF : (ra_pkg::HALF - MW'(1));
	assign range_bad = (pd_q > ra_pkg::HALF - MW'(1)) || (pm_q > neg_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_num_q <= '0;
			acc_den_q <= OW'(1);
		end else if (cmd.op == ra_pkg::OP_COMMIT && !err1_q && !range_bad) begin
			acc_num_q <= pn_q ? OW'(~pm_q + MW'(1)) : OW'(pm_q);
			acc_den_q <= OW'(pd_q);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ra_pkg::OP_LOAD: begin
				kind_q <= ra_pkg::kind_t'(kind);
				on_q <= in_on ^ in_dn;
				om_q <= in_om;
				dmag_q <= in_dmag;
				an_q <= acc_num_q[OW-1];
				am_q <= acc_num_q[OW-1] ? (~acc_num_q + OW'(1)) : acc_num_q;
				ad_q <= acc_den_q;
				err1_q <= 1'b0;
			end
			ra_pkg::OP_PREP: begin
				if ((kind_q == ra_pkg::KIND_LOAD || kind_q == ra_pkg::KIND_ADD)
						&& dmag_q == '0) begin
					err1_q <= 1'b1;
				end else if (kind_q == ra_pkg::KIND_LOAD) begin
					pn_q <= eff_on;
					pm_q <= MW'(om_q);
					pd_q <= MW'(dmag_q);
				end else if (kind_q != ra_pkg::KIND_ADD) begin
					pn_q <= sum_n;
					pm_q <= sum_m;
					pd_q <= MW'(ad_q);
				end
			end
			ra_pkg::OP_MUL_A: prod_a_q <= mul_p;
			ra_pkg::OP_MUL_B: prod_b_q <= mul_p;
			ra_pkg::OP_MUL_D: pd_q <= mul_p;
			ra_pkg::OP_SUM: begin
				pn_q <= sum_n;
				pm_q <= sum_m;
			end
			ra_pkg::OP_GCD_INIT: begin
				if (pm_q == '0) begin
					pn_q <= 1'b0;
					pd_q <= MW'(1);
				end
				ga_q <= pm_q;
				gb_q <= pd_q;
				gk_q <= '0;
			end
			ra_pkg::OP_GCD_STEP: begin
				if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					gk_q <= gk_q + ra_pkg::K_W'(1);
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q > gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			ra_pkg::OP_DIVN_INIT: begin
				div_dvs_q <= ga_q << gk_q;
				div_rem_q <= '0;
				div_quo_q <= pm_q;
				div_cnt_q <= ra_pkg::CNT_W'(MW);
			end
			ra_pkg::OP_DIVD_INIT: begin
				div_rem_q <= '0;
				div_quo_q <= pd_q;
				div_cnt_q <= ra_pkg::CNT_W'(MW);
			end
			ra_pkg::OP_DIV_STEP: begin
				div_rem_q <= rem_ge ? rem_sub : rem_sh;
				div_quo_q <= {div_quo_q[MW-2:0], rem_ge};
				div_cnt_q <= div_cnt_q - ra_pkg::CNT_W'(1);
			end
			ra_pkg::OP_WB_N: pm_q <= div_quo_q;
			ra_pkg::OP_WB_D: pd_q <= div_quo_q;
			ra_pkg::OP_COMMIT: begin
				if (err1_q) begin
					res_num_q <= acc_num_q;
					res_den_q <= acc_den_q;
					res_err_q <= ra_pkg::ERR_ZERO_DEN;
				end else if (range_bad) begin
					res_num_q <= acc_num_q;
					res_den_q <= acc_den_q;
					res_err_q <= ra_pkg::ERR_OVERFLOW;
				end else begin
					res_num_q <= pn_q ? OW'(~pm_q + MW'(1)) : OW'(pm_q);
					res_den_q <= OW'(pd_q);
					res_err_q <= ra_pkg::ERR_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign status.kind = kind_q;
	assign status.den_zero = (dmag_q == '0);
	assign status.num_zero = (pm_q == '0);
	assign status.gcd_done = (ga_q == gb_q);
	assign status.div_done = (div_cnt_q == '0);

	assign result_numerator = res_num_q;
	assign result_denominator = res_den_q[ra_pkg::DEN_OUT_W-1:0];
	assign error = res_err_q;

endmodule

// ----- rtl/ra_checker.sv -----
// ----------------------------------------------------------------------------
// ra_checker
// port-level checks on the rational accumulator unit
// ----------------------------------------------------------------------------
module ra_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [ra_pkg::OPD_W-1:0]    result_numerator,
	input logic [ra_pkg::DEN_OUT_W-1:0]       result_denominator,
	input logic [1:0]                         error
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_numerator)
			&& $stable(result_denominator) && $stable(error))
		else $error("result changed while stalled");

	// one transaction in flight: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a transaction while busy");

	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_denominator != '0)
		else $error("zero denominator shown");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_numerator == '0 |-> result_denominator == 1)
		else $error("zero value not normalised");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error != 2'd3)
		else $error("undefined error code");

endmodule

bind rational_accumulator_unit ra_checker u_ra_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_stall           (in_stall),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.result_numerator   (result_numerator),
	.result_denominator (result_denominator),
	.error              (error)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the rational accumulator unit against a bit-exact predictor of the
// reduced value and error code, with directed corner cases, random fraction
// sequences that include zero denominators and random idling on both channels
// ----------------------------------------------------------------------------
module testbench;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [1:0]                       kind = ra_pkg::KIND_INC;
	logic signed [ra_pkg::OPD_W-1:0]  operand_numerator = '0;
	logic signed [ra_pkg::OPD_W-1:0]  operand_denominator = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic signed [ra_pkg::OPD_W-1:0]  result_numerator;
	logic [ra_pkg::DEN_OUT_W-1:0]     result_denominator;
	logic [1:0]                       error;

	typedef struct packed {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic [1:0]         err;
	} value_t;

	// predictor copy of the accumulated value
	logic signed [63:0] value_num;
	logic [63:0]        value_den;
	value_t             expected_values[$];

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  fault_count    = 0;
	int  sent_count     = 0;
	int  checked_count  = 0;
	int  error_count    = 0;

	rational_accumulator_unit dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .operand_numerator(operand_numerator),
		.operand_denominator(operand_denominator), .out_valid(out_valid),
		.out_stall(out_stall), .result_numerator(result_numerator),
		.result_denominator(result_denominator), .error(error)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
		logic [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// reduce, range check and take the new value; gives the error code
	function automatic logic [1:0] reduce_and_take(bit neg, logic [63:0] mag,
			logic [63:0] den);
		logic [63:0] half;
		logic [63:0] g;
		half = 64'd1 << (ra_pkg::EFF_W - 1);
		if (mag == 0) begin
			neg = 1'b0;
			den = 1;
		end else begin
			g = euclid(mag, den);
			mag = mag / g;
			den = den / g;
		end
		if (den > half - 1) return ra_pkg::ERR_OVERFLOW;
		if (neg ? (mag > half) : (mag > half - 1)) return ra_pkg::ERR_OVERFLOW;
		value_num = neg ? -$signed(mag) : $signed(mag);
		value_den = den;
		return ra_pkg::ERR_OK;
	endfunction

	// signed magnitude sum of two terms
	function automatic void sm_sum(bit an, logic [63:0] am, bit bn, logic [63:0] bm,
			output bit rn, output logic [63:0] rm);
		if (an == bn) begin
			rn = an;
			rm = am + bm;
		end else if (am >= bm) begin
			rn = an;
			rm = am - bm;
		end else begin
			rn = bn;
			rm = bm - am;
		end
	endfunction

	function automatic void predict_value(logic [1:0] k, logic signed [31:0] on_raw,
			logic signed [31:0] od_raw);
		bit          an, onn, dn, rn;
		logic [63:0] am, om, dm, rm;
		logic [1:0]  e;
		value_t      v;
		an = value_num < 0;
		am = an ? -value_num : value_num;
		onn = on_raw[31];
		om = onn ? 64'h1_0000_0000 - {32'd0, on_raw} : {32'd0, on_raw};
		dn = od_raw[31];
		dm = dn ? 64'h1_0000_0000 - {32'd0, od_raw} : {32'd0, od_raw};
		if (k == ra_pkg::KIND_LOAD || k == ra_pkg::KIND_ADD) begin
			if (dm == 0) e = ra_pkg::ERR_ZERO_DEN;
			else begin
				if (dn) onn = !onn;
				if (om == 0) onn = 1'b0;
				if (k == ra_pkg::KIND_LOAD) e = reduce_and_take(onn, om, dm);
				else begin
					sm_sum(an, am * dm, onn, om * value_den, rn, rm);
					e = reduce_and_take(rn, rm, value_den * dm);
				end
			end
		end else begin
			sm_sum(an, am, k == ra_pkg::KIND_DEC, value_den, rn, rm);
			e = reduce_and_take(rn, rm, value_den);
		end
		v.num = value_num[31:0];
		v.den = value_den[30:0];
		v.err = e;
		expected_values.push_back(v);
	endfunction

	// one input transaction, prediction made on acceptance; in_valid is left
	// high so that a following transaction can go out back to back
	task automatic send_fraction(logic [1:0] k, logic signed [31:0] n,
			logic signed [31:0] d);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		operand_numerator <= n;
		operand_denominator <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_value(k, n, d);
		sent_count++;
		@(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		value_t want;
		if (arst_n && out_valid && !out_stall) begin
			checked_count++;
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d err %0d", $time,
					result_numerator, result_denominator, error);
				fault_count++;
			end else begin
				want = expected_values.pop_front();
				if (error != ra_pkg::ERR_OK) error_count++;
				if (result_numerator !== want.num || result_denominator !== want.den ||
						error !== want.err) begin
					$display("%0t: mismatch expected %0d/%0d err %0d actual %0d/%0d err %0d",
						$time, want.num, want.den, want.err, result_numerator,
						result_denominator, error);
					fault_count++;
				end
			end
		end
	end

	// receiver stalling
	always @(negedge clk) begin
		out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// drop valid and hold off until every outstanding result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_values.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [31:0] random_small(int span);
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	task automatic test_directed();
		send_fraction(ra_pkg::KIND_INC, 32'sd0, 32'sd0);
		send_fraction(ra_pkg::KIND_DEC, -32'sd1, 32'sd5);
		send_fraction(ra_pkg::KIND_DEC, 32'sd0, 32'sd0);
		send_fraction(ra_pkg::KIND_LOAD, 32'sd6, -32'sd4);
		send_fraction(ra_pkg::KIND_ADD, 32'sd1, 32'sd2);
		send_fraction(ra_pkg::KIND_ADD, 32'sd3, 32'sd4);
		send_fraction(ra_pkg::KIND_ADD, 32'sd5, 32'sd4);       // equal denominators
		send_fraction(ra_pkg::KIND_LOAD, 32'sd7, 32'sd0);      // zero denominator
		send_fraction(ra_pkg::KIND_ADD, 32'sd7, 32'sd0);
		send_fraction(ra_pkg::KIND_LOAD, 32'sd1, 32'h8000_0000); // denominator of -2^31
		send_fraction(ra_pkg::KIND_LOAD, 32'h8000_0000, 32'sd1);
		send_fraction(ra_pkg::KIND_DEC, 32'sd0, 32'sd0);        // below range
		send_fraction(ra_pkg::KIND_LOAD, 32'h7fff_ffff, 32'sd1);
		send_fraction(ra_pkg::KIND_INC, 32'sd0, 32'sd0);        // above range
		send_fraction(ra_pkg::KIND_LOAD, 32'h8000_0000, 32'h8000_0000);
		send_fraction(ra_pkg::KIND_LOAD, 32'sd0, -32'sd9);       // zero value
		send_fraction(ra_pkg::KIND_LOAD, 32'h7fff_ffff, 32'h7fff_fffe);
		send_fraction(ra_pkg::KIND_ADD, 32'h7fff_fffe, 32'h7fff_ffff);
		send_fraction(ra_pkg::KIND_LOAD, -32'sd1, 32'h7fff_ffff);
		send_fraction(ra_pkg::KIND_ADD, 32'h8000_0000, 32'h7fff_fffd);
		send_fraction(ra_pkg::KIND_ADD, 32'hffff_ffff, 32'hffff_ffff);
		send_fraction(ra_pkg::KIND_LOAD, 32'h5555_5555, 32'haaaa_aaab);
		send_fraction(ra_pkg::KIND_ADD, 32'haaaa_aaaa, 32'h5555_5555);
	endtask

	// mostly short chains of small fractions, some full range noise
	task automatic test_random(int count);
		int          pick;
		logic [1:0]  k;
		logic signed [31:0] n, d;
		repeat (count) begin
			pick = $urandom_range(99);
			k = 2'($urandom_range(3));
			if (pick < 70) begin
				n = random_small(40);
				d = random_small(12);
			end else if (pick < 90) begin
				n = $urandom;
				d = $urandom;
			end else begin
				n = random_small(3000);
				d = (pick < 95) ? 32'sd0 : random_small(60000);
			end
			if ($urandom_range(9) == 0) k = ra_pkg::KIND_LOAD;
			send_fraction(k, n, d);
		end
	endtask

	task automatic test_idling();
		send_idle_pct = 57; recv_stall_pct = 0;
		test_random(100);
		send_idle_pct = 0; recv_stall_pct = 57;
		test_random(100);
		// sender holds off until every result is back
		wait_drained();
		send_idle_pct = 29; recv_stall_pct = 29;
		test_random(100);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		value_num = 0;
		value_den = 1;
		test_directed();
		test_random(150);
		test_idling();
		send_idle_pct = 0; recv_stall_pct = 0;
		test_random(30);
		wait_drained();
		repeat (400) @(negedge clk);
		$display("sent %0d transactions, checked %0d results, %0d with error codes",
			sent_count, checked_count, error_count);
		$display("covered loads, adds, steps, zero denominators, overflow, idling");
		if (fault_count == 0 && expected_values.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// generous watchdog
	initial begin
		#4_000_000;
		$display("timeout after %0d transactions", sent_count);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ra_pkg.sv
rtl/ra_ctrl.sv
rtl/ra_datapath.sv
rtl/rational_accumulator_unit.sv
rtl/ra_checker.sv
test/testbench.sv
